@@ rtl/cubic_bezier_point_eval_core_macros.svh @@
// Assertion macros shared by the cubic Bezier core RTL.
`ifndef CUBIC_BEZIER_POINT_EVAL_CORE_MACROS_SVH
`define CUBIC_BEZIER_POINT_EVAL_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define CBEZ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cbez assertion failed");
// Checked at every edge, reset included.
`define CBEZ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cbez assertion failed");
`else
`define CBEZ_ASSERT(label, clk, rst_n, prop)
`define CBEZ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/cbez_pkg.sv @@
// Widths, constants and types for the cubic Bezier point core.
`default_nettype none

package cbez_pkg;

  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;

  // packed point: three coordinates
  localparam int PT_W   = 3 * COORD_BITS;
  // curve parameter, 0 .. 1.0 inclusive
  localparam int PW     = PARAM_FRAC_BITS + 1;
  localparam int T3W    = PW + 2;
  localparam int SQW    = 2 * PW;
  localparam int TU3W   = T3W + PW;
  // widest raw weight product
  localparam int MW     = TU3W + PW;
  // Bernstein weights, each at most 2^(3F)
  localparam int W_W    = 3 * PARAM_FRAC_BITS + 1;
  localparam int WS_W   = W_W + 2;
  localparam int SHIFT  = 3 * PARAM_FRAC_BITS;
  localparam int PROD_W = W_W + COORD_BITS;
  localparam int SUM_W  = PROD_W + 2;
  localparam int QW     = SUM_W - SHIFT;

  localparam logic [PW-1:0] T_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
  localparam logic [WS_W-1:0] W_TOTAL = {{(WS_W - SHIFT - 1){1'b0}}, 1'b1, {SHIFT{1'b0}}};
  localparam logic signed [SUM_W-1:0] RND_HALF =
    {{(SUM_W - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};
  localparam logic signed [QW-1:0] Q_MAX = QW'(2 ** (COORD_BITS - 1) - 1);
  localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);

  // weights plus control points, handed from weight pipe to blend pipe
  typedef struct packed {
    logic [3:0][W_W-1:0]  wgt;
    logic [3:0][PT_W-1:0] pts;
  } wgt_item_t;

endpackage

`default_nettype wire

@@ rtl/cbez_in_if.sv @@
// Input channel: four control points and a curve parameter.
`default_nettype none

interface cbez_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [cbez_pkg::PT_W-1:0]                point_a;
  logic [cbez_pkg::PT_W-1:0]                point_b;
  logic [cbez_pkg::PT_W-1:0]                point_c;
  logic [cbez_pkg::PT_W-1:0]                point_d;
  logic [cbez_pkg::PW-1:0]                  curve_param;

  modport source (output valid, point_a, point_b, point_c, point_d, curve_param,
                  input ready);
  modport sink (input valid, point_a, point_b, point_c, point_d, curve_param,
                output ready);
endinterface

`default_nettype wire

@@ rtl/cbez_out_if.sv @@
// Output channel: one evaluated curve point.
`default_nettype none

interface cbez_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbez_pkg::COORD_BITS-1:0] out_x;
  logic signed [cbez_pkg::COORD_BITS-1:0] out_y;
  logic signed [cbez_pkg::COORD_BITS-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

@@ rtl/cbez_weight.sv @@
// Two-stage pipe that turns t into the four Bernstein weights.
`default_nettype none

`include "cubic_bezier_point_eval_core_macros.svh"

module cbez_weight (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  cbez_in_if.sink                item_i,
  output cbez_pkg::wgt_item_t    wgt_o,
  output logic                   wgt_valid_o,
  input  wire logic              wgt_ready_i
);

  logic [cbez_pkg::PW-1:0]   t_sat, u_cur;
  logic [cbez_pkg::T3W-1:0]  t3;
  logic                      rdy_s1, rdy_s2;

  // stage 1: squares and 3*t*u
  logic                          s1_valid_q;
  logic [cbez_pkg::SQW-1:0]      uu_q, tt_q;
  logic [cbez_pkg::TU3W-1:0]     tu3_q;
  logic [cbez_pkg::PW-1:0]       t_q, u_q;
  logic [3:0][cbez_pkg::PT_W-1:0] pts_q;

  // stage 2: weights
  logic                          s2_valid_q;
  cbez_pkg::wgt_item_t           s2_q, s2_d;
  logic [cbez_pkg::MW-1:0]       m0, m1, m2, m3;
  logic [cbez_pkg::WS_W-1:0]     wgt_sum;

  assign rdy_s2 = !s2_valid_q || wgt_ready_i;
  assign rdy_s1 = !s1_valid_q || rdy_s2;
  assign item_i.ready = rdy_s1;

  always_comb begin
    t_sat = (item_i.curve_param > cbez_pkg::T_ONE) ? cbez_pkg::T_ONE : item_i.curve_param;
    u_cur = cbez_pkg::T_ONE - t_sat;
    t3    = cbez_pkg::T3W'(t_sat) + cbez_pkg::T3W'({t_sat, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (rdy_s1) s1_valid_q <= item_i.valid;
      if (rdy_s2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && rdy_s1) begin
      uu_q  <= cbez_pkg::SQW'(u_cur) * cbez_pkg::SQW'(u_cur);
      tt_q  <= cbez_pkg::SQW'(t_sat) * cbez_pkg::SQW'(t_sat);
      tu3_q <= cbez_pkg::TU3W'(t3) * cbez_pkg::TU3W'(u_cur);
      t_q   <= t_sat;
      u_q   <= u_cur;
      pts_q <= {item_i.point_d, item_i.point_c, item_i.point_b, item_i.point_a};
    end
  end

  always_comb begin
    m0 = cbez_pkg::MW'(uu_q) * cbez_pkg::MW'(u_q);
    m1 = cbez_pkg::MW'(tu3_q) * cbez_pkg::MW'(u_q);
    m2 = cbez_pkg::MW'(tu3_q) * cbez_pkg::MW'(t_q);
    m3 = cbez_pkg::MW'(tt_q) * cbez_pkg::MW'(t_q);
    s2_d.wgt[0] = m0[cbez_pkg::W_W-1:0];
    s2_d.wgt[1] = m1[cbez_pkg::W_W-1:0];
    s2_d.wgt[2] = m2[cbez_pkg::W_W-1:0];
    s2_d.wgt[3] = m3[cbez_pkg::W_W-1:0];
    s2_d.pts    = pts_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && rdy_s2) s2_q <= s2_d;
  end

  assign wgt_o       = s2_q;
  assign wgt_valid_o = s2_valid_q;

  assign wgt_sum = cbez_pkg::WS_W'(s2_q.wgt[0]) + cbez_pkg::WS_W'(s2_q.wgt[1]) +
                   cbez_pkg::WS_W'(s2_q.wgt[2]) + cbez_pkg::WS_W'(s2_q.wgt[3]);

  // Bernstein weights always add up to exactly 1.0
  `CBEZ_ASSERT(a_wgt_sum, clk_i, rst_ni, s2_valid_q |-> wgt_sum == cbez_pkg::W_TOTAL)
  `CBEZ_ASSERT(a_s2_hold, clk_i, rst_ni, s2_valid_q && !wgt_ready_i |=> s2_valid_q && $stable(s2_q))
  `CBEZ_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !s1_valid_q && !s2_valid_q)

endmodule

`default_nettype wire

@@ rtl/cbez_blend.sv @@
// Blend pipe: weight times coordinate, then sum, round and clamp per axis.
`default_nettype none

`include "cubic_bezier_point_eval_core_macros.svh"

module cbez_blend (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cbez_pkg::wgt_item_t wgt_i,
  input  wire logic              wgt_valid_i,
  output logic                   wgt_ready_o,
  cbez_out_if.source             result_o
);

  logic rdy_s3, rdy_s4;

  // stage 3: twelve products, [axis][point]
  logic                                         s3_valid_q;
  logic signed [2:0][3:0][cbez_pkg::PROD_W-1:0] prod_q, prod_d;

  // stage 4: output register
  logic                                         o_valid_q;
  logic signed [2:0][cbez_pkg::COORD_BITS-1:0]  res_q, res_d;
  logic [2:0]                                   clamp_hit;

  logic signed [cbez_pkg::SUM_W-1:0]            acc [3];
  logic signed [cbez_pkg::QW-1:0]               quo [3];

  assign rdy_s4      = !o_valid_q || result_o.ready;
  assign rdy_s3      = !s3_valid_q || rdy_s4;
  assign wgt_ready_o = rdy_s3;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      for (int k = 0; k < 4; k++) begin
        prod_d[ax][k] =
          cbez_pkg::PROD_W'($signed({1'b0, wgt_i.wgt[k]})) *
          cbez_pkg::PROD_W'($signed(wgt_i.pts[k][ax*cbez_pkg::COORD_BITS +: cbez_pkg::COORD_BITS]));
      end
    end
  end

  // floor(sum / 2^3F + 1/2), then saturate
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      acc[ax] = cbez_pkg::SUM_W'($signed(prod_q[ax][0])) +
                cbez_pkg::SUM_W'($signed(prod_q[ax][1])) +
                cbez_pkg::SUM_W'($signed(prod_q[ax][2])) +
                cbez_pkg::SUM_W'($signed(prod_q[ax][3])) + cbez_pkg::RND_HALF;
      quo[ax] = cbez_pkg::QW'(acc[ax] >>> cbez_pkg::SHIFT);
      clamp_hit[ax] = 1'b1;
      if (quo[ax] > cbez_pkg::Q_MAX) begin
        res_d[ax] = cbez_pkg::COORD_BITS'(cbez_pkg::Q_MAX);
      end else if (quo[ax] < cbez_pkg::Q_MIN) begin
        res_d[ax] = cbez_pkg::COORD_BITS'(cbez_pkg::Q_MIN);
      end else begin
        res_d[ax] = quo[ax][cbez_pkg::COORD_BITS-1:0];
        clamp_hit[ax] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (rdy_s3) s3_valid_q <= wgt_valid_i;
      if (rdy_s4) o_valid_q  <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wgt_valid_i && rdy_s3) prod_q <= prod_d;
    if (s3_valid_q && rdy_s4)  res_q  <= res_d;
  end

  assign result_o.valid = o_valid_q;
  assign result_o.out_x = res_q[0];
  assign result_o.out_y = res_q[1];
  assign result_o.out_z = res_q[2];

  // convex combination of in-range points never needs the clamp
  `CBEZ_ASSERT(a_no_clamp, clk_i, rst_ni, s3_valid_q && rdy_s4 |-> clamp_hit == 3'b000)
  `CBEZ_ASSERT(a_s3_kept, clk_i, rst_ni, s3_valid_q && !rdy_s4 |=> s3_valid_q && $stable(prod_q))
  `CBEZ_ASSERT(a_out_hold, clk_i, rst_ni, o_valid_q && !result_o.ready |=> o_valid_q && $stable(res_q))

endmodule

`default_nettype wire

@@ rtl/cubic_bezier_point_eval_core.sv @@
// Top level of the cubic Bezier point evaluator.
`default_nettype none

// Evaluates one point of a cubic Bezier curve per item: four signed Q8.8
// xyz control points and t in Q1.16 (values above 1.0 saturate to 1.0)
// give the exactly rounded (half up) curve point. Fully pipelined: one
// item per clock when not stalled, through four register stages (stage 1,
// stage 2, stage 3, output register). Two stages build the Bernstein
// weights (t^2, u^2, 3tu, then the cubic terms), one stage forms the
// twelve weight-by-coordinate products, and the last adds, rounds and
// clamps into the output register. Each stage holds when the one after
// it is full, so back-pressure on the output stalls the pipe without
// losing items, and bubbles are squeezed out while stalled.

module cubic_bezier_point_eval_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cbez_in_if.sink    item_i,
  cbez_out_if.source result_o
);

  cbez_pkg::wgt_item_t wgt;
  logic                wgt_valid;
  logic                wgt_ready;

  cbez_weight u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .wgt_o       (wgt),
    .wgt_valid_o (wgt_valid),
    .wgt_ready_i (wgt_ready)
  );

  cbez_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wgt_i       (wgt),
    .wgt_valid_i (wgt_valid),
    .wgt_ready_o (wgt_ready),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
